@@ rtl/mklc_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mklc_pkg
// Shared types, codes and Morse code tables for the Latin/Cyrillic keyer.
// ----------------------------------------------------------------------------
package mklc_pkg;

    localparam int CNT_W = 16;
    localparam int CMP_W = ((CNT_W > 16) ? CNT_W : 16) + 1;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_SKIP = 2'd1;
    localparam logic [1:0] ST_BUSY = 2'd2;

    localparam logic OP_CHAR = 1'b0;
    localparam logic OP_TICK = 1'b1;

    localparam logic REG_UNIT_TICKS = 1'b0;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_LEAD,
        PH_ON,
        PH_OFF,
        PH_GAP
    } phase_t;

    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_CODE,
        KIND_SPACE,
        KIND_SPECIAL
    } kind_t;

    // bit i of pat is element i, 1 = dash
    typedef struct packed {
        logic [2:0] len;
        logic [5:0] pat;
    } morse_code_t;

    typedef struct packed {
        kind_t       kind;
        morse_code_t code;
    } lookup_t;

    function automatic morse_code_t latin_code(input logic [4:0] idx);
        morse_code_t c;
        case (idx)
            5'd0:    c = '{3'd2, 6'b000010};
            5'd1:    c = '{3'd4, 6'b000001};
            5'd2:    c = '{3'd4, 6'b000101};
            5'd3:    c = '{3'd3, 6'b000001};
            5'd4:    c = '{3'd1, 6'b000000};
            5'd5:    c = '{3'd4, 6'b000100};
            5'd6:    c = '{3'd3, 6'b000011};
            5'd7:    c = '{3'd4, 6'b000000};
            5'd8:    c = '{3'd2, 6'b000000};
            5'd9:    c = '{3'd4, 6'b001110};
            5'd10:   c = '{3'd3, 6'b000101};
            5'd11:   c = '{3'd4, 6'b000010};
            5'd12:   c = '{3'd2, 6'b000011};
            5'd13:   c = '{3'd2, 6'b000001};
            5'd14:   c = '{3'd3, 6'b000111};
            5'd15:   c = '{3'd4, 6'b000110};
            5'd16:   c = '{3'd4, 6'b001011};
            5'd17:   c = '{3'd3, 6'b000010};
            5'd18:   c = '{3'd3, 6'b000000};
            5'd19:   c = '{3'd1, 6'b000001};
            5'd20:   c = '{3'd3, 6'b000100};
            5'd21:   c = '{3'd4, 6'b001000};
            5'd22:   c = '{3'd3, 6'b000110};
            5'd23:   c = '{3'd4, 6'b001001};
            5'd24:   c = '{3'd4, 6'b001101};
            5'd25:   c = '{3'd4, 6'b000011};
            default: c = '{3'd0, 6'b000000};
        endcase
        return c;
    endfunction

    function automatic morse_code_t cyr_code(input logic [4:0] idx);
        morse_code_t c;
        case (idx)
            5'd0:    c = '{3'd2, 6'b000010};
            5'd1:    c = '{3'd4, 6'b000001};
            5'd2:    c = '{3'd3, 6'b000110};
            5'd3:    c = '{3'd3, 6'b000011};
            5'd4:    c = '{3'd3, 6'b000001};
            5'd5:    c = '{3'd1, 6'b000000};
            5'd6:    c = '{3'd4, 6'b001000};
            5'd7:    c = '{3'd4, 6'b000011};
            5'd8:    c = '{3'd2, 6'b000000};
            5'd9:    c = '{3'd4, 6'b001110};
            5'd10:   c = '{3'd3, 6'b000101};
            5'd11:   c = '{3'd4, 6'b000010};
            5'd12:   c = '{3'd2, 6'b000011};
            5'd13:   c = '{3'd2, 6'b000001};
            5'd14:   c = '{3'd3, 6'b000111};
            5'd15:   c = '{3'd4, 6'b000110};
            5'd16:   c = '{3'd3, 6'b000010};
            5'd17:   c = '{3'd3, 6'b000000};
            5'd18:   c = '{3'd1, 6'b000001};
            5'd19:   c = '{3'd3, 6'b000100};
            5'd20:   c = '{3'd4, 6'b000100};
            5'd21:   c = '{3'd4, 6'b000000};
            5'd22:   c = '{3'd4, 6'b000101};
            5'd23:   c = '{3'd4, 6'b000111};
            5'd24:   c = '{3'd4, 6'b001111};
            5'd25:   c = '{3'd4, 6'b001011};
            5'd26:   c = '{3'd5, 6'b010110};
            5'd27:   c = '{3'd4, 6'b001101};
            5'd28:   c = '{3'd4, 6'b001001};
            5'd29:   c = '{3'd5, 6'b000100};
            5'd30:   c = '{3'd4, 6'b001100};
            5'd31:   c = '{3'd4, 6'b001010};
            default: c = '{3'd0, 6'b000000};
        endcase
        return c;
    endfunction

    function automatic morse_code_t digit_code(input logic [3:0] idx);
        morse_code_t c;
        case (idx)
            4'd0:    c = '{3'd5, 6'b011111};
            4'd1:    c = '{3'd5, 6'b011110};
            4'd2:    c = '{3'd5, 6'b011100};
            4'd3:    c = '{3'd5, 6'b011000};
            4'd4:    c = '{3'd5, 6'b010000};
            4'd5:    c = '{3'd5, 6'b000000};
            4'd6:    c = '{3'd5, 6'b000001};
            4'd7:    c = '{3'd5, 6'b000011};
            4'd8:    c = '{3'd5, 6'b000111};
            4'd9:    c = '{3'd5, 6'b001111};
            default: c = '{3'd0, 6'b000000};
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

@@ rtl/mklc_lookup.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mklc_lookup
// Case-folds one UTF-16 code unit and returns its Morse class and code.
// ----------------------------------------------------------------------------
module mklc_lookup (
    input  wire logic [15:0]      char_code,
    output mklc_pkg::lookup_t     result
);
    import mklc_pkg::*;

    logic [15:0] lat_fold;
    logic [15:0] folded;
    logic [15:0] lat_off;
    logic [15:0] cyr_off;
    logic [15:0] dig_off;

    always_comb
    begin
        lat_fold = (char_code >= 16'h0061 && char_code <= 16'h007A)
                 ? char_code - 16'h0020 : char_code;
        folded   = (lat_fold >= 16'h0430 && lat_fold <= 16'h044F)
                 ? lat_fold - 16'h0020 : lat_fold;
        lat_off  = folded - 16'h0041;
        cyr_off  = folded - 16'h0410;
        dig_off  = folded - 16'h0030;

        result.kind = KIND_NONE;
        result.code = '{3'd0, 6'b000000};
        if (folded >= 16'h0041 && folded <= 16'h005A)
        begin
            result.kind = KIND_CODE;
            result.code = latin_code(lat_off[4:0]);
        end
        else if (folded >= 16'h0410 && folded <= 16'h042F)
        begin
            result.kind = KIND_CODE;
            result.code = cyr_code(cyr_off[4:0]);
        end
        else if (folded >= 16'h0030 && folded <= 16'h0039)
        begin
            result.kind = KIND_CODE;
            result.code = digit_code(dig_off[3:0]);
        end
        else
        begin
            case (folded)
                16'h0020:
                begin
                    result.kind = KIND_SPACE;
                end
                16'h002E:
                begin
                    result.kind = KIND_SPECIAL;
                    result.code = '{3'd6, 6'b000000};
                end
                16'h0021:
                begin
                    result.kind = KIND_SPECIAL;
                    result.code = '{3'd6, 6'b110011};
                end
                16'h002C:
                begin
                    result.kind = KIND_SPECIAL;
                    result.code = '{3'd6, 6'b101010};
                end
                16'h003F:
                begin
                    result.kind = KIND_SPECIAL;
                    result.code = '{3'd6, 6'b001100};
                end
                16'h002D:
                begin
                    result.kind = KIND_SPECIAL;
                    result.code = '{3'd6, 6'b100001};
                end
                16'h002F:
                begin
                    result.kind = KIND_SPECIAL;
                    result.code = '{3'd5, 6'b001001};
                end
                default:
                begin
                    result.kind = KIND_NONE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

@@ rtl/morse_keyer_latin_cyrillic_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// morse_keyer_latin_cyrillic_core
// Morse keyer: character words load a code, tick words step the LED.
// ----------------------------------------------------------------------------
// Each input word yields exactly one result word. A word is taken every cycle
// while results are drained; it passes an input register, the combinational
// table lookup or counter update, and a result register. The unit length
// (register 0, byte address 0, 16 bits, reset 1) counts tick words per Morse
// unit; writing 0 is ignored. A character word sent while a character is
// still being keyed is refused with status 2, an unsupported one is skipped
// with status 1.
module morse_keyer_latin_cyrillic_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    input  wire logic        item_valid,
    output logic             item_ready,
    input  wire logic        operation,
    input  wire logic [15:0] char_code,
    input  wire logic        last_char,
    output logic             res_valid,
    input  wire logic        res_ready,
    output logic             led,
    output logic      [1:0]  status,
    output logic             ready_res,
    output logic             text_done
);
    import mklc_pkg::*;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    // configuration
    logic [15:0] unit_ticks_reg;
    logic        cfg_wr;

    // input stage
    logic        in_valid_reg;
    logic        op_reg;
    logic [15:0] char_reg;
    logic        last_reg;
    logic        advance;

    // keyer state
    phase_t           phase_reg,        phase_next;
    logic [5:0]       code_pattern_reg, code_pattern_next;
    logic [2:0]       elements_left_reg, elements_left_next;
    logic [CNT_W-1:0] unit_counter_reg, unit_counter_next;
    logic [2:0]       units_left_reg,   units_left_next;
    logic             final_flag_reg,   final_flag_next;

    // result stage
    logic        res_valid_reg;
    logic        led_reg,   led_next;
    logic [1:0]  status_reg, status_next;
    logic        ready_reg, ready_next;
    logic        done_reg,  done_next;

    lookup_t     lk;
    logic [CMP_W-1:0] cnt_inc;
    logic        unit_end;
    logic [2:0]  ul_dec;
    logic [2:0]  el_dec;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_UNIT_TICKS);
    assign prdata = (paddr[2] == REG_UNIT_TICKS) ? {16'd0, unit_ticks_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            unit_ticks_reg <= 16'd1;
        end
        else if (cfg_wr && pready && (pwdata[15:0] != 16'd0))
        begin
            unit_ticks_reg <= pwdata[15:0];
        end
    end

    assign advance    = in_valid_reg && (!res_valid_reg || res_ready);
    assign item_ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (item_ready)
        begin
            in_valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            op_reg   <= operation;
            char_reg <= char_code;
            last_reg <= last_char;
        end
    end

    mklc_lookup u_lookup (
        .char_code (char_reg),
        .result    (lk)
    );

    always_comb
    begin
        cnt_inc  = CMP_W'(unit_counter_reg) + CMP_W'(1);
        unit_end = (cnt_inc >= CMP_W'(unit_ticks_reg)) || (unit_counter_reg == CNT_MAX);
        ul_dec   = (units_left_reg != 3'd0) ? units_left_reg - 3'd1 : 3'd0;
        el_dec   = (elements_left_reg != 3'd0) ? elements_left_reg - 3'd1 : 3'd0;

        phase_next         = phase_reg;
        code_pattern_next  = code_pattern_reg;
        elements_left_next = elements_left_reg;
        unit_counter_next  = unit_counter_reg;
        units_left_next    = units_left_reg;
        final_flag_next    = final_flag_reg;
        led_next           = 1'b0;
        status_next        = ST_OK;
        ready_next         = 1'b0;
        done_next          = 1'b0;

        if (op_reg == OP_CHAR)
        begin
            if (phase_reg != PH_IDLE)
            begin
                status_next = ST_BUSY;
            end
            else if (lk.kind == KIND_NONE)
            begin
                status_next = ST_SKIP;
                ready_next  = 1'b1;
            end
            else
            begin
                final_flag_next    = last_reg;
                unit_counter_next  = '0;
                code_pattern_next  = 6'd0;
                elements_left_next = 3'd0;
                case (lk.kind)
                    KIND_SPACE:
                    begin
                        phase_next      = PH_GAP;
                        units_left_next = last_reg ? 3'd2 : 3'd4;
                    end
                    KIND_SPECIAL:
                    begin
                        code_pattern_next  = lk.code.pat;
                        elements_left_next = lk.code.len;
                        phase_next         = PH_LEAD;
                        units_left_next    = 3'd4;
                    end
                    default:
                    begin
                        code_pattern_next  = lk.code.pat;
                        elements_left_next = lk.code.len;
                        phase_next         = PH_ON;
                        units_left_next    = lk.code.pat[0] ? 3'd3 : 3'd1;
                    end
                endcase
            end
        end
        else if (phase_reg != PH_IDLE)
        begin
            led_next = (phase_reg == PH_ON);
            if (unit_end)
            begin
                unit_counter_next = '0;
                units_left_next   = ul_dec;
                if (ul_dec == 3'd0)
                begin
                    case (phase_reg)
                        PH_LEAD:
                        begin
                            phase_next      = PH_ON;
                            units_left_next = code_pattern_reg[0] ? 3'd3 : 3'd1;
                        end
                        PH_ON:
                        begin
                            phase_next      = PH_OFF;
                            units_left_next = 3'd1;
                        end
                        PH_OFF:
                        begin
                            elements_left_next = el_dec;
                            code_pattern_next  = {1'b0, code_pattern_reg[5:1]};
                            if (el_dec != 3'd0)
                            begin
                                phase_next      = PH_ON;
                                units_left_next = code_pattern_reg[1] ? 3'd3 : 3'd1;
                            end
                            else if (final_flag_reg)
                            begin
                                phase_next      = PH_IDLE;
                                ready_next      = 1'b1;
                                done_next       = 1'b1;
                                final_flag_next = 1'b0;
                            end
                            else
                            begin
                                phase_next      = PH_GAP;
                                units_left_next = 3'd2;
                            end
                        end
                        default:
                        begin
                            phase_next      = PH_IDLE;
                            ready_next      = 1'b1;
                            done_next       = final_flag_reg;
                            final_flag_next = 1'b0;
                        end
                    endcase
                end
            end
            else
            begin
                unit_counter_next = unit_counter_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_IDLE;
            code_pattern_reg  <= 6'd0;
            elements_left_reg <= 3'd0;
            unit_counter_reg  <= '0;
            units_left_reg    <= 3'd0;
            final_flag_reg    <= 1'b0;
        end
        else if (advance)
        begin
            phase_reg         <= phase_next;
            code_pattern_reg  <= code_pattern_next;
            elements_left_reg <= elements_left_next;
            unit_counter_reg  <= unit_counter_next;
            units_left_reg    <= units_left_next;
            final_flag_reg    <= final_flag_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            led_reg    <= led_next;
            status_reg <= status_next;
            ready_reg  <= ready_next;
            done_reg   <= done_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign led       = led_reg;
    assign status    = status_reg;
    assign ready_res = ready_reg;
    assign text_done = done_reg;

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && done_reg |-> ready_reg)
        else $error("text_done without ready_res");

    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && led_reg |-> status_reg == ST_OK)
        else $error("led on with non-ok status");

    assert property (@(posedge clk) disable iff (!rst_n)
        unit_ticks_reg != 16'd0)
        else $error("unit length is zero");

    assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_IDLE |-> !final_flag_reg)
        else $error("last flag held while idle");

    assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg != PH_IDLE |-> units_left_reg != 3'd0)
        else $error("active phase with no units left");
`endif

endmodule

`default_nettype wire

@@ tb/mklc_checker.sv @@
// ----------------------------------------------------------------------------
// mklc_checker
// Predicts every keyer result word and compares it with the one the core sends.
// ----------------------------------------------------------------------------
// This module follows the unit length through the register port and keeps its
// own copy of the keyer state. Each input word that is taken adds one
// expected result word to a queue. Each result word that is taken is checked
// field by field against the oldest entry in that queue. The failure count and
// the number of results still outstanding are passed to the testbench top.
module mklc_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic        pready,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    input  wire logic        item_valid,
    input  wire logic        item_ready,
    input  wire logic        operation,
    input  wire logic [15:0] char_code,
    input  wire logic        last_char,
    input  wire logic        res_valid,
    input  wire logic        res_ready,
    input  wire logic        led,
    input  wire logic [1:0]  status,
    input  wire logic        ready_res,
    input  wire logic        text_done,
    output int               fail_count,
    output int               pending_words
);
    import mklc_pkg::*;

    typedef struct packed {
        logic       led;
        logic [1:0] status;
        logic       ready_res;
        logic       text_done;
    } keyer_result_t;

    keyer_result_t    expected_results[$];
    keyer_result_t    oldest;

    logic [15:0]      unit_len;
    phase_t           key_phase;
    logic [5:0]       dash_bits;
    logic [2:0]       marks_left;
    logic [CNT_W-1:0] tick_count;
    logic [2:0]       units_to_go;
    logic             ends_text;
    logic             lead_gap;

    function automatic string latin_morse(input int idx);
        case (idx)
            0: return ".-";     1: return "-...";   2: return "-.-.";   3: return "-..";
            4: return ".";      5: return "..-.";   6: return "--.";    7: return "....";
            8: return "..";     9: return ".---";   10: return "-.-";   11: return ".-..";
            12: return "--";    13: return "-.";    14: return "---";   15: return ".--.";
            16: return "--.-";  17: return ".-.";   18: return "...";   19: return "-";
            20: return "..-";   21: return "...-";  22: return ".--";   23: return "-..-";
            24: return "-.--";  25: return "--..";
            default: return "";
        endcase
    endfunction

    function automatic string cyrillic_morse(input int idx);
        case (idx)
            0: return ".-";     1: return "-...";   2: return ".--";    3: return "--.";
            4: return "-..";    5: return ".";      6: return "...-";   7: return "--..";
            8: return "..";     9: return ".---";   10: return "-.-";   11: return ".-..";
            12: return "--";    13: return "-.";    14: return "---";   15: return ".--.";
            16: return ".-.";   17: return "...";   18: return "-";     19: return "..-";
            20: return "..-.";  21: return "....";  22: return "-.-.";  23: return "---.";
            24: return "----";  25: return "--.-";  26: return ".--.-"; 27: return "-.--";
            28: return "-..-";  29: return "..-.."; 30: return "..--";  31: return ".-.-";
            default: return "";
        endcase
    endfunction

    function automatic string digit_morse(input int idx);
        case (idx)
            0: return "-----";  1: return ".----";  2: return "..---";  3: return "...--";
            4: return "....-";  5: return ".....";  6: return "-....";  7: return "--...";
            8: return "---..";  9: return "----.";
            default: return "";
        endcase
    endfunction

    function automatic morse_code_t dots_to_code(input string s);
        morse_code_t mc;
        mc = '0;
        for (int i = 0; i < s.len(); i++)
        begin
            if (s[i] == "-")
                mc.pat[i] = 1'b1;
            mc.len = mc.len + 3'd1;
        end
        return mc;
    endfunction

    function automatic kind_t classify(input logic [15:0] raw, output morse_code_t mc);
        logic [15:0] c;
        c = raw;
        mc = '0;
        if (c >= 16'h0061 && c <= 16'h007A)
            c = c - 16'h0020;
        if (c >= 16'h0430 && c <= 16'h044F)
            c = c - 16'h0020;
        if (c >= 16'h0041 && c <= 16'h005A)
        begin
            mc = dots_to_code(latin_morse(int'(c - 16'h0041)));
            return KIND_CODE;
        end
        if (c >= 16'h0410 && c <= 16'h042F)
        begin
            mc = dots_to_code(cyrillic_morse(int'(c - 16'h0410)));
            return KIND_CODE;
        end
        if (c >= 16'h0030 && c <= 16'h0039)
        begin
            mc = dots_to_code(digit_morse(int'(c - 16'h0030)));
            return KIND_CODE;
        end
        if (c == 16'h0020)
            return KIND_SPACE;
        case (c)
            16'h002E: mc = dots_to_code("......");
            16'h0021: mc = dots_to_code("--..--");
            16'h002C: mc = dots_to_code(".-.-.-");
            16'h003F: mc = dots_to_code("..--..");
            16'h002D: mc = dots_to_code("-....-");
            16'h002F: mc = dots_to_code("-..-.");
            default: return KIND_NONE;
        endcase
        return KIND_SPECIAL;
    endfunction

    function automatic void start_element();
        key_phase = PH_ON;
        units_to_go = dash_bits[0] ? 3'd3 : 3'd1;
    endfunction

    function automatic keyer_result_t advance_keyer(input logic op, input logic [15:0] ch,
                                                    input logic lst);
        keyer_result_t r;
        morse_code_t   mc;
        kind_t         kind;
        r = '0;
        if (op == OP_CHAR)
        begin
            if (key_phase != PH_IDLE)
                r.status = ST_BUSY;
            else
            begin
                kind = classify(ch, mc);
                if (kind == KIND_NONE)
                begin
                    r.status = ST_SKIP;
                    r.ready_res = 1'b1;
                end
                else
                begin
                    ends_text = lst;
                    tick_count = '0;
                    dash_bits = '0;
                    marks_left = '0;
                    lead_gap = 1'b0;
                    if (kind == KIND_SPACE)
                    begin
                        key_phase = PH_GAP;
                        units_to_go = lst ? 3'd2 : 3'd4;
                    end
                    else
                    begin
                        dash_bits = mc.pat;
                        marks_left = mc.len;
                        if (kind == KIND_SPECIAL)
                        begin
                            lead_gap = 1'b1;
                            key_phase = PH_LEAD;
                            units_to_go = 3'd4;
                        end
                        else
                            start_element();
                    end
                end
            end
        end
        else if (key_phase != PH_IDLE)
        begin
            r.led = (key_phase == PH_ON);
            if (int'(tick_count) + 1 >= int'(unit_len) || &tick_count)
            begin
                tick_count = '0;
                if (units_to_go != 3'd0)
                    units_to_go = units_to_go - 3'd1;
                if (units_to_go == 3'd0)
                begin
                    case (key_phase)
                        PH_LEAD:
                        begin
                            lead_gap = 1'b0;
                            start_element();
                        end
                        PH_ON:
                        begin
                            key_phase = PH_OFF;
                            units_to_go = 3'd1;
                        end
                        PH_OFF:
                        begin
                            if (marks_left != 3'd0)
                                marks_left = marks_left - 3'd1;
                            dash_bits = dash_bits >> 1;
                            if (marks_left != 3'd0)
                                start_element();
                            else if (ends_text)
                            begin
                                key_phase = PH_IDLE;
                                r.ready_res = 1'b1;
                                r.text_done = 1'b1;
                                ends_text = 1'b0;
                            end
                            else
                            begin
                                key_phase = PH_GAP;
                                units_to_go = 3'd2;
                            end
                        end
                        default:
                        begin
                            key_phase = PH_IDLE;
                            r.ready_res = 1'b1;
                            r.text_done = ends_text;
                            ends_text = 1'b0;
                        end
                    endcase
                end
            end
            else
                tick_count = tick_count + 1'b1;
        end
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [1:0] want,
                                        input logic [1:0] got);
        if (got !== want)
        begin
            fail_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            unit_len = 16'd1;
            key_phase = PH_IDLE;
            dash_bits = '0;
            marks_left = '0;
            tick_count = '0;
            units_to_go = '0;
            ends_text = 1'b0;
            lead_gap = 1'b0;
            expected_results.delete();
            fail_count = 0;
            pending_words <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready && paddr[2] == REG_UNIT_TICKS
                && pwdata[15:0] != 16'd0)
                unit_len = pwdata[15:0];
            if (item_valid && item_ready)
                expected_results.push_back(advance_keyer(operation, char_code, last_char));
            if (res_valid && res_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: unexpected result word, expected none, actual %0d %0d %0d %0d",
                             $time, led, status, ready_res, text_done);
                end
                else
                begin
                    oldest = expected_results.pop_front();
                    check_field("led", oldest.led, led);
                    check_field("status", oldest.status, status);
                    check_field("ready_res", oldest.ready_res, ready_res);
                    check_field("text_done", oldest.text_done, text_done);
                end
            end
            pending_words <= expected_results.size();
        end
    end

endmodule

@@ tb/tb_morse_keyer_latin_cyrillic_core.sv @@
// ----------------------------------------------------------------------------
// tb_morse_keyer_latin_cyrillic_core
// Stimulus and verdict for the Latin/Cyrillic Morse keyer core.
// ----------------------------------------------------------------------------
// The testbench starts with a short directed pass at the reset unit length:
// an idle tick, unsupported characters at both ends of the code range, a
// refused character, a final space and a punctuation mark. After that it
// keys random characters and feeds tick words until the core reports the
// character finished. Busy characters, bursts of ticks and pauses are mixed
// in. The unit length is changed between phases, from 1 to 65535. Sender
// and receiver stall at random, and the checker beside the core predicts and
// compares every result word.
module tb_morse_keyer_latin_cyrillic_core;
    import mklc_pkg::*;

    localparam logic [2:0] ADDR_UNIT_TICKS = {REG_UNIT_TICKS, 2'b00};
    localparam logic [2:0] ADDR_SPARE      = 3'd4;
    localparam int         RESET_CYCLES    = 11;
    localparam int         SETTLE_CYCLES   = 4;
    localparam int         LIMIT_TIME      = 8 * 400000;

    logic        clk        = 1'b0;
    logic        rst_n      = 1'b0;
    logic        psel       = 1'b0;
    logic        penable    = 1'b0;
    logic        pwrite     = 1'b0;
    logic [2:0]  paddr      = '0;
    logic [31:0] pwdata     = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        item_valid = 1'b0;
    logic        item_ready;
    logic        operation  = OP_TICK;
    logic [15:0] char_code  = '0;
    logic        last_char  = 1'b0;
    logic        res_valid;
    logic        res_ready  = 1'b0;
    logic        led;
    logic [1:0]  status;
    logic        ready_res;
    logic        text_done;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int words_sent    = 0;
    int keyer_frees   = 0;
    int unit_span     = 1;
    int fail_count;
    int pending_words;

    morse_keyer_latin_cyrillic_core DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .operation  (operation),
        .char_code  (char_code),
        .last_char  (last_char),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .led        (led),
        .status     (status),
        .ready_res  (ready_res),
        .text_done  (text_done)
    );

    mklc_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .pready        (pready),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .item_valid    (item_valid),
        .item_ready    (item_ready),
        .operation     (operation),
        .char_code     (char_code),
        .last_char     (last_char),
        .res_valid     (res_valid),
        .res_ready     (res_ready),
        .led           (led),
        .status        (status),
        .ready_res     (ready_res),
        .text_done     (text_done),
        .fail_count    (fail_count),
        .pending_words (pending_words)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
        res_ready <= rst_n && ($urandom_range(99) >= recv_idle_pct);

    always @(posedge clk)
        if (res_valid && res_ready && ready_res)
            keyer_frees <= keyer_frees + 1;

    function automatic logic [15:0] random_char();
        case ($urandom_range(9))
            0: return 16'(16'h0041 + $urandom_range(25));
            1: return 16'(16'h0061 + $urandom_range(25));
            2: return 16'(16'h0410 + $urandom_range(31));
            3: return 16'(16'h0430 + $urandom_range(31));
            4: return 16'(16'h0030 + $urandom_range(9));
            5: return 16'h0020;
            7: return 16'($urandom_range(65535));
            8:
            begin
                case ($urandom_range(9))
                    0: return 16'h0040;
                    1: return 16'h005B;
                    2: return 16'h0060;
                    3: return 16'h007B;
                    4: return 16'h040F;
                    5: return 16'h0450;
                    6: return 16'h003A;
                    7: return 16'h001F;
                    8: return 16'h0022;
                    default: return 16'hFFFF;
                endcase
            end
            default:
            begin
                case ($urandom_range(5))
                    0: return 16'h002E;
                    1: return 16'h0021;
                    2: return 16'h002C;
                    3: return 16'h003F;
                    4: return 16'h002D;
                    default: return 16'h002F;
                endcase
            end
        endcase
    endfunction

    task automatic send_word(input logic op, input logic [15:0] ch, input logic lst);
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        operation  <= op;
        char_code  <= ch;
        last_char  <= lst;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        words_sent++;
    endtask

    task automatic send_tick();
        send_word(OP_TICK, 16'($urandom_range(65535)), 1'($urandom_range(1)));
    endtask

    // advance the keyer until it reports the current character finished or the word limit runs out
    task automatic tick_until_free(input int since);
        int n;
        n = 0;
        while (keyer_frees == since && n < 30 * unit_span + 8)
        begin
            if ($urandom_range(99) < 3)
                send_word(OP_CHAR, random_char(), 1'($urandom_range(1)));
            else
                send_tick();
            n++;
        end
    endtask

    task automatic key_char(input logic [15:0] ch, input logic lst);
        int since;
        since = keyer_frees;
        send_word(OP_CHAR, ch, lst);
        tick_until_free(since);
    endtask

    task automatic drain();
        item_valid <= 1'b0;
        @(posedge clk);
        while (pending_words != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_unit(input logic [31:0] data);
        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        write_reg(ADDR_UNIT_TICKS, data);
        if (data[15:0] != 16'd0)
            unit_span = int'(data[15:0]);
    endtask

    task automatic run_phase(input int stop_at);
        int pick;
        int burst;
        while (words_sent < stop_at)
        begin
            pick = $urandom_range(99);
            if (pick < 80)
                key_char(random_char(), $urandom_range(3) == 0);
            else if (pick < 88)
                send_word(OP_CHAR, random_char(), 1'($urandom_range(1)));
            else if (pick < 97)
            begin
                burst = $urandom_range(6, 1);
                repeat (burst) send_tick();
            end
            else
                drain();
        end
    endtask

    initial
    begin
        #LIMIT_TIME;
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        int since;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_tick();
        send_word(OP_CHAR, 16'hFFFF, 1'b1);
        send_word(OP_CHAR, 16'h0000, 1'b0);
        since = keyer_frees;
        send_word(OP_CHAR, 16'h0065, 1'b1);
        send_word(OP_CHAR, 16'h005A, 1'b0);
        tick_until_free(since);
        key_char(16'h0020, 1'b1);
        key_char(16'h002E, 1'b1);

        set_unit(32'h0000_0000);
        write_reg(ADDR_SPARE, 32'h0000_0007);
        set_unit(32'h0000_0002);
        send_idle_pct = 22;
        recv_idle_pct = 53;
        run_phase(words_sent + 650);

        set_unit(32'hFFFF_0003);
        send_idle_pct = 53;
        recv_idle_pct = 22;
        run_phase(words_sent + 650);

        set_unit(32'h0001_0000);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_phase(words_sent + 300);

        set_unit(32'h0000_FFFF);
        since = keyer_frees;
        send_word(OP_CHAR, 16'h0045, 1'b1);
        repeat (300) send_tick();
        set_unit(32'h0000_0001);
        tick_until_free(since);

        set_unit(32'($urandom_range(4, 1)));
        run_phase(words_sent + 400);

        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending_words == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

@@ morse_keyer_latin_cyrillic_core.f @@
rtl/mklc_pkg.sv
rtl/mklc_lookup.sv
rtl/morse_keyer_latin_cyrillic_core.sv
tb/mklc_checker.sv
tb/tb_morse_keyer_latin_cyrillic_core.sv
